// ===== rtl/i2cram_pkg.sv =====
// types and codes shared by the register access master
// no dependencies

package i2cram_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_START   = 4'd1,
    ST_ADDR_W  = 4'd2,
    ST_REG     = 4'd3,
    ST_DATA    = 4'd4,
    ST_RESTART = 4'd5,
    ST_ADDR_R  = 4'd6,
    ST_RECV    = 4'd7,
    ST_STOP    = 4'd8
  } step_e;

  localparam logic [6:0] SlaveAddrReset = 7'd104;
  localparam logic [3:0] BitsPerByte    = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       refused;
  } out_item_t;

endpackage

// ===== rtl/i2c_register_access_master_core.sv =====
// bit-level two-wire bus master, one register read or write per request
// depends on i2cram_pkg and i2cram_skid
// usage:
//   each input item is one bus tick carrying a function code, register index,
//   write byte and the sampled data line level. every item yields exactly one
//   result item with the clock and data levels to drive for that tick, busy,
//   done, the last received byte and a refused flag.
//   a read or write request taken while idle starts driving on the same tick;
//   a request taken while busy is dropped and flagged refused.
//   the slave address register is written through cfg_we_i / cfg_wdata_i and
//   is picked up at the next address byte.
// throughput:
//   one item per clock cycle while in_stall_o is low. the tick is evaluated in
//   the cycle it is accepted and its result is registered in the output buffer.
//   the transaction sequencer state is the only loop.
// reset:
//   the sequencer returns to idle, slave address is 104, read byte is zero.
// stall:
//   a stalled result holds; one more item is taken into the skid register,
//   after which in_stall_o rises until the output drains.

module i2c_register_access_master_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cram_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cram_pkg::out_item_t out_item_o,
  input  logic                  cfg_we_i,
  input  logic [6:0]            cfg_wdata_i
);
  import i2cram_pkg::*;

  logic [6:0] addr_q;
  step_e      step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       is_write_q, is_write_d;
  logic [7:0] held_reg_q, held_reg_d;
  logic [7:0] held_data_q, held_data_d;
  logic [7:0] rx_q, rx_d;

  logic       fire;
  logic       request;
  logic       start_now;
  step_e      cur_step;
  logic [1:0] cur_phase;
  logic [3:0] cur_cnt;
  logic [7:0] cur_shift;
  out_item_t  res;

  function automatic logic [7:0] load_shift(step_e s, logic [6:0] addr,
                                            logic [7:0] hreg, logic [7:0] hdata);
    logic [7:0] v;
    unique case (s)
      ST_ADDR_W: v = {addr, 1'b0};
      ST_ADDR_R: v = {addr, 1'b1};
      ST_REG:    v = hreg;
      ST_DATA:   v = hdata;
      default:   v = 8'd0;
    endcase
    return v;
  endfunction

  assign request   = (in_item_i.func == FUNC_READ) || (in_item_i.func == FUNC_WRITE);
  assign start_now = (step_q == ST_IDLE) && request;
  assign cur_step  = start_now ? ST_START : step_q;
  assign cur_phase = start_now ? 2'd0 : phase_q;
  assign cur_cnt   = start_now ? 4'd0 : cnt_q;
  assign cur_shift = start_now ? 8'd0 : shift_q;
  assign fire      = in_valid_i & ~in_stall_o;

  // next state
  always_comb begin
    step_e nxt;
    logic  enter;
    nxt         = ST_IDLE;
    enter       = 1'b0;
    step_d      = cur_step;
    phase_d     = cur_phase;
    cnt_d       = cur_cnt;
    shift_d     = cur_shift;
    rx_d        = rx_q;
    is_write_d  = start_now ? (in_item_i.func == FUNC_WRITE) : is_write_q;
    held_reg_d  = start_now ? in_item_i.reg_addr : held_reg_q;
    held_data_d = start_now ? in_item_i.write_data : held_data_q;
    unique case (cur_step) inside
      ST_START, ST_RESTART: begin
        if (cur_phase[1]) begin
          enter = 1'b1;
          nxt   = (cur_step == ST_START) ? ST_ADDR_W : ST_ADDR_R;
        end else begin
          phase_d = cur_phase + 2'd1;
        end
      end
      ST_STOP: begin
        if (cur_phase[1]) begin
          enter = 1'b1;
          nxt   = ST_IDLE;
        end else begin
          phase_d = cur_phase + 2'd1;
        end
      end
      ST_RECV: begin
        if (cur_phase == 2'd0) begin
          phase_d = 2'd1;
        end else begin
          phase_d = 2'd0;
          if (cur_cnt < BitsPerByte) begin
            shift_d = {cur_shift[6:0], in_item_i.sda_in};
            cnt_d   = cur_cnt + 4'd1;
            if (cur_cnt + 4'd1 == BitsPerByte) begin
              rx_d = {cur_shift[6:0], in_item_i.sda_in};
            end
          end else begin
            enter = 1'b1;
            nxt   = ST_STOP;
          end
        end
      end
      ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R: begin
        if (cur_phase == 2'd0) begin
          phase_d = 2'd1;
        end else begin
          phase_d = 2'd0;
          if (cur_cnt < BitsPerByte) begin
            shift_d = {cur_shift[6:0], 1'b0};
            cnt_d   = cur_cnt + 4'd1;
          end else begin
            enter = 1'b1;
            unique case (cur_step)
              ST_ADDR_W: nxt = ST_REG;
              ST_REG:    nxt = is_write_d ? ST_DATA : ST_RESTART;
              ST_ADDR_R: nxt = ST_RECV;
              default:   nxt = ST_STOP;
            endcase
          end
        end
      end
      default: begin
        step_d  = ST_IDLE;
      end
    endcase
    if (enter) begin
      step_d  = nxt;
      phase_d = 2'd0;
      cnt_d   = 4'd0;
      shift_d = load_shift(nxt, addr_q, held_reg_d, held_data_d);
    end
  end

  // outputs of the tick
  always_comb begin
    res           = '0;
    res.scl_out   = 1'b1;
    res.sda_out   = 1'b1;
    res.busy_res  = 1'b1;
    res.read_byte = rx_d;
    res.refused   = request && !start_now && (step_q != ST_IDLE);
    unique case (cur_step) inside
      ST_START, ST_RESTART: begin
        res.scl_out = (cur_phase != 2'd0);
        res.sda_out = !cur_phase[1];
      end
      ST_STOP: begin
        res.scl_out  = (cur_phase != 2'd0);
        res.sda_out  = cur_phase[1];
        res.done_res = cur_phase[1];
      end
      ST_RECV: begin
        res.scl_out = cur_phase[0];
      end
      ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R: begin
        res.scl_out = cur_phase[0];
        res.sda_out = (cur_cnt < BitsPerByte) ? cur_shift[7] : 1'b1;
      end
      default: begin
        res.busy_res = 1'b0;
        res.refused  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= SlaveAddrReset;
      step_q      <= ST_IDLE;
      phase_q     <= 2'd0;
      cnt_q       <= 4'd0;
      shift_q     <= 8'd0;
      is_write_q  <= 1'b0;
      held_reg_q  <= 8'd0;
      held_data_q <= 8'd0;
      rx_q        <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      if (fire) begin
        step_q      <= step_d;
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        shift_q     <= shift_d;
        is_write_q  <= is_write_d;
        held_reg_q  <= held_reg_d;
        held_data_q <= held_data_d;
        rx_q        <= rx_d;
      end
    end
  end

  i2cram_skid u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/i2cram_skid.sv =====
// two-entry output buffer for result items, main register plus skid register
// depends on i2cram_pkg

module i2cram_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cram_pkg::out_item_t in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cram_pkg::out_item_t out_item_o
);
  import i2cram_pkg::*;

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      pop;
  logic      push;

  assign pop         = main_valid_q & ~out_stall_i;
  assign push        = in_valid_i & ~skid_valid_q;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_d       = in_item_i;
        skid_valid_d = 1'b1;
      end else begin
        main_d       = in_item_i;
        main_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for i2c_register_access_master_core
// drives bus ticks and register transactions, checks every result item against
// a local bus sequencer model; depends on i2cram_pkg and the core rtl
`timescale 1ns / 1ps

module testbench;
  import i2cram_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_kind_e;

  localparam int QuietLimit = 1000;

  logic       clk_i;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;

  // bus sequencer model state
  step_e      m_step  = ST_IDLE;
  logic [1:0] m_phase = '0;
  logic [3:0] m_count = '0;
  logic [7:0] m_shift = '0;
  logic       m_write = 1'b0;
  logic [7:0] m_reg   = '0;
  logic [7:0] m_data  = '0;
  logic [7:0] m_rx    = '0;
  logic [6:0] m_addr  = SlaveAddrReset;

  out_item_t   bus_levels_q[$];
  int          mismatches   = 0;
  int          items_sent   = 0;
  int          burst_left   = 0;
  bit          steady       = 1'b0;
  int          quiet_cycles = 0;
  stall_kind_e stall_kind   = STALL_NONE;
  int          stall_left   = 0;

  i2c_register_access_master_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void load_step(step_e s);
    m_step  = s;
    m_phase = '0;
    m_count = '0;
    case (s)
      ST_ADDR_W: m_shift = {m_addr, 1'b0};
      ST_ADDR_R: m_shift = {m_addr, 1'b1};
      ST_REG:    m_shift = m_reg;
      ST_DATA:   m_shift = m_data;
      default:   m_shift = '0;
    endcase
  endfunction

  function automatic step_e step_after_byte(step_e s);
    case (s)
      ST_ADDR_W: return ST_REG;
      ST_REG:    return m_write ? ST_DATA : ST_RESTART;
      ST_DATA:   return ST_STOP;
      ST_ADDR_R: return ST_RECV;
      default:   return ST_STOP;
    endcase
  endfunction

  function automatic out_item_t bus_tick(in_item_t it);
    out_item_t r;
    logic      req;
    req = (it.func == FUNC_READ) || (it.func == FUNC_WRITE);
    r = '0;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    if (m_step == ST_IDLE) begin
      if (req) begin
        m_reg   = it.reg_addr;
        m_data  = it.write_data;
        m_write = (it.func == FUNC_WRITE);
        load_step(ST_START);
      end
    end else if (req) begin
      r.refused = 1'b1;
    end
    if (m_step != ST_IDLE) begin
      r.busy_res = 1'b1;
      case (m_step) inside
        ST_START, ST_RESTART: begin
          r.scl_out = (m_phase != 2'd0);
          r.sda_out = (m_phase < 2'd2);
          if (m_phase >= 2'd2) load_step(m_step == ST_START ? ST_ADDR_W : ST_ADDR_R);
          else m_phase++;
        end
        ST_STOP: begin
          r.scl_out = (m_phase != 2'd0);
          r.sda_out = (m_phase >= 2'd2);
          if (m_phase >= 2'd2) begin
            r.done_res = 1'b1;
            load_step(ST_IDLE);
          end else begin
            m_phase++;
          end
        end
        ST_RECV: begin
          r.scl_out = m_phase[0];
          r.sda_out = 1'b1;
          if (m_phase == 2'd0) begin
            m_phase = 2'd1;
          end else begin
            m_phase = 2'd0;
            if (m_count < BitsPerByte) begin
              m_shift = {m_shift[6:0], it.sda_in};
              m_count++;
              if (m_count == BitsPerByte) m_rx = m_shift;
            end else begin
              load_step(ST_STOP);
            end
          end
        end
        default: begin
          r.scl_out = m_phase[0];
          r.sda_out = (m_count < BitsPerByte) ? m_shift[7] : 1'b1;
          if (m_phase == 2'd0) begin
            m_phase = 2'd1;
          end else begin
            m_phase = 2'd0;
            if (m_count < BitsPerByte) begin
              m_shift = {m_shift[6:0], 1'b0};
              m_count++;
            end else begin
              load_step(step_after_byte(m_step));
            end
          end
        end
      endcase
    end
    r.read_byte = m_rx;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_levels(out_item_t got, out_item_t exp);
    if (got.scl_out !== exp.scl_out)
      report_mismatch($sformatf("scl_out %b, expected %b", got.scl_out, exp.scl_out));
    if (got.sda_out !== exp.sda_out)
      report_mismatch($sformatf("sda_out %b, expected %b", got.sda_out, exp.sda_out));
    if (got.busy_res !== exp.busy_res)
      report_mismatch($sformatf("busy_res %b, expected %b", got.busy_res, exp.busy_res));
    if (got.done_res !== exp.done_res)
      report_mismatch($sformatf("done_res %b, expected %b", got.done_res, exp.done_res));
    if (got.read_byte !== exp.read_byte)
      report_mismatch($sformatf("read_byte %h, expected %h", got.read_byte, exp.read_byte));
    if (got.refused !== exp.refused)
      report_mismatch($sformatf("refused %b, expected %b", got.refused, exp.refused));
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (bus_levels_q.size() == 0)
        report_mismatch($sformatf("result %h with nothing expected", out_item));
      else
        check_levels(out_item, bus_levels_q.pop_front());
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind <= stall_kind_e'($urandom_range(STALL_NONE, STALL_HEAVY));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_kind)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= (stall_left % 8 < 3);
      default:        out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL i2c_register_access_master_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      if (steady) gap = 0;
      else if ($urandom_range(0, 4) == 0) gap = $urandom_range(5, 20);
      else gap = $urandom_range(0, 3);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall === 1'b1);
    bus_levels_q.push_back(bus_tick(it));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (bus_levels_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_slave_address(logic [6:0] a);
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    m_addr = a;
    @(posedge clk_i);
  endtask

  task automatic send_request(func_e f, logic [7:0] ra, logic [7:0] wd);
    in_item_t it;
    it.func       = f;
    it.reg_addr   = ra;
    it.write_data = wd;
    it.sda_in     = 1'($urandom);
    send_item(it);
  endtask

  // ticks until idle or max_ticks, with optional noise and requests at stop; rx supplies the slave's data bits
  task automatic finish_transaction(logic [7:0] rx, int noise_pct, bit hit_stop,
                                    int max_ticks);
    in_item_t it;
    int       n;
    n = 0;
    while (m_step != ST_IDLE && n < max_ticks) begin
      it.func       = FUNC_TICK;
      it.reg_addr   = 8'($urandom);
      it.write_data = 8'($urandom);
      it.sda_in     = 1'($urandom);
      if (m_step == ST_RECV && m_phase == 2'd1 && m_count < BitsPerByte)
        it.sda_in = rx[3'd7 - m_count[2:0]];
      if ($urandom_range(0, 99) < noise_pct)
        it.func = func_e'($urandom_range(FUNC_READ, FUNC_RSVD));
      if (hit_stop && m_step == ST_STOP && m_phase == 2'd2)
        it.func = func_e'($urandom_range(FUNC_READ, FUNC_WRITE));
      send_item(it);
      n++;
    end
  endtask

  task automatic run_transaction(func_e f, logic [7:0] ra, logic [7:0] wd, logic [7:0] rx,
                                 int noise_pct, bit hit_stop);
    send_request(f, ra, wd);
    finish_transaction(rx, noise_pct, hit_stop, 1000);
  endtask

  task automatic test_plain_ticks();
    in_item_t it;
    for (int i = 0; i < 6; i++) begin
      it.func       = (i % 2 == 1) ? FUNC_RSVD : FUNC_TICK;
      it.reg_addr   = (i / 2 == 1) ? 8'hff : 8'h00;
      it.write_data = ~it.reg_addr;
      it.sda_in     = (i < 3);
      send_item(it);
    end
  endtask

  task automatic test_register_write();
    drain_results();
    set_slave_address(7'h7f);
    run_transaction(FUNC_WRITE, 8'h00, 8'hff, 8'h00, 10, 1'b1);
    drain_results();
    set_slave_address(7'h00);
    run_transaction(FUNC_WRITE, 8'hff, 8'h00, 8'h00, 0, 1'b0);
  endtask

  task automatic test_register_read();
    run_transaction(FUNC_READ, 8'ha5, 8'h00, 8'hff, 0, 1'b1);
    run_transaction(FUNC_READ, 8'h5a, 8'hff, 8'h00, 10, 1'b0);
    run_transaction(FUNC_READ, 8'h81, 8'h7e, 8'ha5, 0, 1'b0);
  endtask

  // address moves mid transaction and is used from the next address byte
  task automatic test_address_change();
    drain_results();
    set_slave_address(7'h7f);
    send_request(FUNC_READ, 8'h3c, 8'h00);
    finish_transaction(8'h00, 0, 1'b0, 38);
    drain_results();
    set_slave_address(7'h15);
    finish_transaction(8'h6b, 0, 1'b0, 1000);
    send_request(FUNC_WRITE, 8'hc3, 8'h96);
    drain_results();
    set_slave_address(SlaveAddrReset);
    finish_transaction(8'h00, 0, 1'b0, 1000);
  endtask

  task automatic test_random_traffic();
    in_item_t   it;
    func_e      f;
    logic [7:0] rx;
    int         idle_ticks;
    int         pick;
    while (items_sent < 700) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        drain_results();
        pick = $urandom_range(0, 3);
        set_slave_address(pick == 0 ? 7'h00 : pick == 1 ? 7'h7f : 7'($urandom));
      end
      idle_ticks = $urandom_range(0, 5);
      for (int i = 0; i < idle_ticks; i++) begin
        it.func       = $urandom_range(0, 1) ? FUNC_RSVD : FUNC_TICK;
        it.reg_addr   = 8'($urandom);
        it.write_data = 8'($urandom);
        it.sda_in     = 1'($urandom);
        send_item(it);
      end
      f  = $urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE;
      rx = 8'($urandom);
      send_request(f, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        finish_transaction(rx, 0, 1'b0, $urandom_range(0, 80));
        drain_results();
        set_slave_address(7'($urandom));
      end
      finish_transaction(rx, $urandom_range(0, 15), $urandom_range(0, 2) == 0, 1000);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_plain_ticks();
    test_register_write();
    test_register_read();
    test_address_change();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (bus_levels_q.size() != 0) report_mismatch("results still expected at end of run");
    if (mismatches == 0) begin
      $display("PASS i2c_register_access_master_core");
    end else begin
      $display("FAIL i2c_register_access_master_core");
    end
    $finish;
  end

endmodule
